[src/jack_and_power_sense_qualifier_macros.svh]
// Assertion macros for the jack and power sense qualifier.
`ifndef JACK_AND_POWER_SENSE_QUALIFIER_MACROS_SVH
`define JACK_AND_POWER_SENSE_QUALIFIER_MACROS_SVH

`ifndef SYNTHESIS

`define JPSQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jpsq assertion failed");

`define JPSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jpsq assertion failed");

`else

`define JPSQ_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define JPSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[src/jpsq_pkg.sv]
// Shared types and constants for the jack and power sense qualifier.
`default_nettype none

package jpsq_pkg;

  localparam int CNT_W      = 8;
  localparam int ADC_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_PERIOD   = 3'd0,
    REG_INSERT_CONFIRM = 3'd1,
    REG_LEVEL_THRESH  = 3'd2,
    REG_LEVEL_CONFIRM = 3'd3,
    REG_DC_THRESH     = 3'd4,
    REG_DC_CONFIRM    = 3'd5
  } reg_idx_t;

  localparam cnt_t POLL_PERIOD_RST = 8'd1;
  localparam cnt_t CONFIRM_RST     = 8'd3;
  localparam logic [ADC_W-1:0] THRESH_RST = 12'd2048;

endpackage

`default_nettype wire

[src/jpsq_debounce.sv]
// Counter debounce: counts consecutive differing readings up to a confirm count.
`default_nettype none

module jpsq_debounce (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             clr,
  input  wire logic             differs,
  input  wire jpsq_pkg::cnt_t   confirm,
  output logic                  accept
);

  jpsq_pkg::cnt_t count;
  jpsq_pkg::cnt_t count_next;
  jpsq_pkg::cnt_t inc;
  logic           hit;

  always_comb begin
    inc    = count + jpsq_pkg::cnt_t'(1);
    hit    = inc >= confirm;
    accept = en && !clr && differs && hit;
    count_next = count;
    if (en) begin
      if (clr || !differs || hit) begin
        count_next = '0;
      end else begin
        count_next = inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

[src/jack_and_power_sense_qualifier.sv]
// Top level: jack insertion, jack level and DC presence qualifier.
// One input beat is one poll tick; the block takes one beat per clock while out_ready
// does not stall it, and gives one result beat per input beat, through the input
// register, then the result register. The throughput is set by the status update loop,
// which closes through the status registers. Configuration writes are taken in any
// cycle (cfg_ready is always high) and must only be issued while idle.
// Thresholds and samples are compared in their low ADC_BITS bits (at most 12).
`default_nettype none

module jack_and_power_sense_qualifier #(
  parameter int ADC_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                driver_ready,
  input  wire logic                                jack_pin,
  input  wire logic [jpsq_pkg::ADC_W-1:0]          jack_adc,
  input  wire logic [jpsq_pkg::ADC_W-1:0]          dc_adc,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     jack_inserted,
  output logic                                     jack_level_low,
  output logic                                     dc_present,
  output logic                                     insert_changed,
  output logic                                     level_changed,
  output logic                                     dc_changed,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [jpsq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [jpsq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  `include "jack_and_power_sense_qualifier_macros.svh"

  localparam int CMP_W = (ADC_BITS < jpsq_pkg::ADC_W) ? ADC_BITS : jpsq_pkg::ADC_W;

  // configuration
  jpsq_pkg::cnt_t   poll_period;
  jpsq_pkg::cnt_t   insert_confirm;
  logic [CMP_W-1:0] level_thresh;
  jpsq_pkg::cnt_t   level_confirm;
  logic [CMP_W-1:0] dc_thresh;
  jpsq_pkg::cnt_t   dc_confirm;

  // input register
  logic                       in_vld;
  logic                       in_drdy;
  logic                       in_pin;
  logic [jpsq_pkg::ADC_W-1:0] in_jadc;
  logic [jpsq_pkg::ADC_W-1:0] in_dadc;

  // state
  jpsq_pkg::cnt_t poll_timer;
  logic           inserted_status;
  logic           level_status;
  logic           recheck_pending;
  logic           dc_status;

  logic           adv;
  logic           run;
  logic           sample;
  logic           ins_acc;
  logic           lvl_acc;
  logic           dc_acc;
  logic           ins_next;
  logic           recheck_mid;
  logic           lvl_low;
  logic           dc_on;
  logic           lvl_next;
  logic           recheck_next;
  logic           dc_next;
  jpsq_pkg::cnt_t poll_timer_next;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld && (!out_valid || out_ready);
  assign in_ready  = !in_vld || adv;
  assign run       = adv && in_drdy;
  assign sample    = poll_timer <= jpsq_pkg::cnt_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_period    <= jpsq_pkg::POLL_PERIOD_RST;
      insert_confirm <= jpsq_pkg::CONFIRM_RST;
      level_thresh   <= jpsq_pkg::THRESH_RST[CMP_W-1:0];
      level_confirm  <= jpsq_pkg::CONFIRM_RST;
      dc_thresh      <= jpsq_pkg::THRESH_RST[CMP_W-1:0];
      dc_confirm     <= jpsq_pkg::CONFIRM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (jpsq_pkg::reg_idx_t'(cfg_index))
        jpsq_pkg::REG_POLL_PERIOD:    poll_period    <= cfg_data[jpsq_pkg::CNT_W-1:0];
        jpsq_pkg::REG_INSERT_CONFIRM: insert_confirm <= cfg_data[jpsq_pkg::CNT_W-1:0];
        jpsq_pkg::REG_LEVEL_THRESH:   level_thresh   <= cfg_data[CMP_W-1:0];
        jpsq_pkg::REG_LEVEL_CONFIRM:  level_confirm  <= cfg_data[jpsq_pkg::CNT_W-1:0];
        jpsq_pkg::REG_DC_THRESH:      dc_thresh      <= cfg_data[CMP_W-1:0];
        jpsq_pkg::REG_DC_CONFIRM:     dc_confirm     <= cfg_data[jpsq_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_drdy <= driver_ready;
      in_pin  <= jack_pin;
      in_jadc <= jack_adc;
      in_dadc <= dc_adc;
    end
  end

  jpsq_debounce u_insert (
    .clk     (clk),
    .rst     (rst),
    .en      (run && sample),
    .clr     (1'b0),
    .differs (in_pin != inserted_status),
    .confirm (insert_confirm),
    .accept  (ins_acc)
  );

  jpsq_debounce u_level (
    .clk     (clk),
    .rst     (rst),
    .en      (run),
    .clr     (!ins_next),
    .differs ((lvl_low != level_status) || recheck_mid),
    .confirm (level_confirm),
    .accept  (lvl_acc)
  );

  jpsq_debounce u_dc (
    .clk     (clk),
    .rst     (rst),
    .en      (run),
    .clr     (1'b0),
    .differs (dc_on != dc_status),
    .confirm (dc_confirm),
    .accept  (dc_acc)
  );

  always_comb begin
    lvl_low     = in_jadc[CMP_W-1:0] <= level_thresh;
    dc_on       = in_dadc[CMP_W-1:0] > dc_thresh;
    ins_next    = ins_acc ? in_pin : inserted_status;
    recheck_mid = ins_acc ? in_pin : recheck_pending;

    lvl_next     = level_status;
    recheck_next = recheck_mid;
    if (run) begin
      if (!ins_next) begin
        lvl_next = 1'b0;
      end else if (lvl_acc) begin
        lvl_next     = lvl_low;
        recheck_next = 1'b0;
      end
    end
    dc_next = dc_acc ? dc_on : dc_status;

    poll_timer_next = poll_timer;
    if (run) begin
      if (sample) begin
        poll_timer_next = poll_period;
      end else begin
        poll_timer_next = poll_timer - jpsq_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_timer      <= '0;
      inserted_status <= 1'b0;
      level_status    <= 1'b0;
      recheck_pending <= 1'b0;
      dc_status       <= 1'b1;
      out_valid       <= 1'b0;
    end else begin
      poll_timer      <= poll_timer_next;
      inserted_status <= ins_next;
      level_status    <= lvl_next;
      recheck_pending <= recheck_next;
      dc_status       <= dc_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      jack_inserted  <= ins_next;
      jack_level_low <= lvl_next;
      dc_present     <= dc_next;
      insert_changed <= ins_acc;
      level_changed  <= lvl_acc;
      dc_changed     <= dc_acc;
    end
  end

  `JPSQ_ASSERT_IMPL(a_lvl_chg_needs_jack, clk, rst, out_valid && level_changed, jack_inserted)
  `JPSQ_ASSERT_IMPL(a_removed_clears_lvl, clk, rst, out_valid && !jack_inserted, !jack_level_low)
  `JPSQ_ASSERT_NEXT(a_freeze_not_ready, clk, rst, !run, $stable(inserted_status) && $stable(level_status) && $stable(dc_status) && $stable(poll_timer))
  `JPSQ_ASSERT_IMPL(a_no_recheck_removed, clk, rst, !inserted_status && !rst, !recheck_pending)

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for the jack and power sense qualifier: directed ticks, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jpsq_pkg::*;

  typedef struct packed {
    logic             ready;
    logic             pin;
    logic [ADC_W-1:0] jadc;
    logic [ADC_W-1:0] dc;
  } tick_t;

  typedef struct packed {
    logic inserted;
    logic level_low;
    logic dc_on;
    logic ins_chg;
    logic lvl_chg;
    logic dc_chg;
  } sense_t;

  typedef struct packed {
    tick_t  t;
    logic   typed;
    sense_t want;
  } row_t;

  typedef struct packed {
    cnt_t             poll;
    cnt_t             ins_conf;
    logic [ADC_W-1:0] lvl_thr;
    cnt_t             lvl_conf;
    logic [ADC_W-1:0] dc_thr;
    cnt_t             dc_conf;
  } settings_t;

  typedef struct packed {
    cnt_t timer;
    cnt_t ins_cnt;
    logic inserted;
    cnt_t lvl_cnt;
    logic lvl_low;
    logic recheck;
    cnt_t dc_cnt;
    logic dc_on;
  } qual_state_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [ADC_W-1:0]     ADC_MAX     = '1;
  localparam int SRC = 0;
  localparam int SNK = 1;
  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD   = 90;
  localparam int NUM_PHASES  = 8;
  localparam int N_ROWS      = 25;

  // held state straight after reset: out, level high, DC present, no change flags
  localparam sense_t HELD_RESET = 6'b001_000;
  localparam sense_t UNTYPED    = 6'b000_000;

  // ready, pin, jack_adc, dc_adc, typed, expected
  localparam row_t SCRIPT [N_ROWS] = '{
    {1'b0, 1'b1, 12'd0,    12'd0,    1'b1, HELD_RESET},
    {1'b0, 1'b1, 12'd4095, 12'd4095, 1'b1, HELD_RESET},
    {1'b1, 1'b1, 12'd0,    12'd0,    1'b1, HELD_RESET},
    {1'b1, 1'b1, 12'd0,    12'd0,    1'b1, HELD_RESET},
    {1'b1, 1'b1, 12'd0,    12'd0,    1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd0,    12'd0,    1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd0,    12'd0,    1'b0, UNTYPED},
    {1'b1, 1'b0, 12'd4095, 12'd4095, 1'b0, UNTYPED},
    {1'b1, 1'b0, 12'd4095, 12'd4095, 1'b0, UNTYPED},
    {1'b1, 1'b0, 12'd4095, 12'd4095, 1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd4095, 12'd4095, 1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd4095, 12'd4095, 1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd4095, 12'd4095, 1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd4095, 12'd4095, 1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd4095, 12'd4095, 1'b0, UNTYPED},
    {1'b1, 1'b0, 12'd2048, 12'd2048, 1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd2049, 12'd2049, 1'b0, UNTYPED},
    {1'b1, 1'b0, 12'd2048, 12'd2048, 1'b0, UNTYPED},
    {1'b1, 1'b0, 12'd2049, 12'd2048, 1'b0, UNTYPED},
    {1'b0, 1'b0, 12'd0,    12'd0,    1'b0, UNTYPED},
    {1'b1, 1'b0, 12'd2048, 12'd2049, 1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd2048, 12'd0,    1'b0, UNTYPED},
    {1'b1, 1'b1, 12'd2049, 12'd4095, 1'b0, UNTYPED},
    {1'b0, 1'b1, 12'd4095, 12'd0,    1'b0, UNTYPED},
    {1'b1, 1'b0, 12'd0,    12'd4095, 1'b0, UNTYPED}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  driver_ready = 1'b0;
  logic                  jack_pin = 1'b0;
  logic [ADC_W-1:0]      jack_adc = '0;
  logic [ADC_W-1:0]      dc_adc = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  jack_inserted;
  logic                  jack_level_low;
  logic                  dc_present;
  logic                  insert_changed;
  logic                  level_changed;
  logic                  dc_changed;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  settings_t   cfg;
  qual_state_t st;
  sense_t      sense_q [$];
  int          bad_beats = 0;
  int          calm_run [2] = '{0, 0};
  logic        pin_want = 1'b0;
  logic        lvl_want = 1'b0;
  logic        dc_want = 1'b1;
  int          pin_left = 0;
  int          lvl_left = 0;
  int          dc_left = 0;

  jack_and_power_sense_qualifier dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [CNT_W:0] debounce(input logic differs, input cnt_t count,
                                              input cnt_t confirm);
    cnt_t bumped;
    bumped = count + 1'b1;
    if (!differs) return '0;
    if (bumped >= confirm) return {1'b1, {CNT_W{1'b0}}};
    return {1'b0, bumped};
  endfunction

  function automatic sense_t qualify_tick(input tick_t t);
    sense_t           r;
    logic [CNT_W:0]   d;
    logic             low;
    logic             on;
    r = '0;
    if (t.ready) begin
      if (st.timer <= 8'd1) begin
        d = debounce(t.pin != st.inserted, st.ins_cnt, cfg.ins_conf);
        st.ins_cnt = d[CNT_W-1:0];
        if (d[CNT_W]) begin
          st.inserted = t.pin;
          st.recheck = t.pin;
          r.ins_chg = 1'b1;
        end
        st.timer = cfg.poll;
      end else begin
        st.timer = st.timer - 1'b1;
      end
      if (st.inserted) begin
        low = t.jadc <= cfg.lvl_thr;
        d = debounce(low != st.lvl_low || st.recheck, st.lvl_cnt, cfg.lvl_conf);
        st.lvl_cnt = d[CNT_W-1:0];
        if (d[CNT_W]) begin
          st.lvl_low = low;
          st.recheck = 1'b0;
          r.lvl_chg = 1'b1;
        end
      end else begin
        st.lvl_low = 1'b0;
        st.lvl_cnt = '0;
      end
      on = t.dc > cfg.dc_thr;
      d = debounce(on != st.dc_on, st.dc_cnt, cfg.dc_conf);
      st.dc_cnt = d[CNT_W-1:0];
      if (d[CNT_W]) begin
        st.dc_on = on;
        r.dc_chg = 1'b1;
      end
    end
    r.inserted = st.inserted;
    r.level_low = st.lvl_low;
    r.dc_on = st.dc_on;
    return r;
  endfunction

  function automatic int next_gap(input int side);
    if (calm_run[side] == 0 && $urandom_range(0, 19) == 0) calm_run[side] = $urandom_range(15, 60);
    if (calm_run[side] != 0) begin
      calm_run[side]--;
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic int run_length(input cnt_t confirm, input int period);
    int span;
    span = (int'(confirm) + 1) * period * 2 + 2;
    if (span > 320) span = 320;
    return $urandom_range(1, span);
  endfunction

  function automatic logic [ADC_W-1:0] adc_near(input logic above, input logic [ADC_W-1:0] thr);
    if ($urandom_range(0, 15) == 0) return ADC_W'($urandom);
    if (above) begin
      if (thr == ADC_MAX) return ADC_MAX;
      if ($urandom_range(0, 4) == 0) return thr + 1'b1;
      return ADC_W'($urandom_range(int'(thr) + 1, int'(ADC_MAX)));
    end
    if ($urandom_range(0, 4) == 0) return thr;
    return ADC_W'($urandom_range(0, int'(thr)));
  endfunction

  // runs of steady readings with random lengths, some flipped samples, some pure noise
  function automatic tick_t random_tick();
    tick_t t;
    int    period;
    t = tick_t'({$urandom, $urandom});
    if ($urandom_range(0, 9) == 0) return t;
    period = (cfg.poll == 0) ? 1 : int'(cfg.poll);
    if (pin_left == 0) begin
      if ($urandom_range(0, 3) != 0) pin_want = ~pin_want;
      pin_left = run_length(cfg.ins_conf, period);
    end
    if (lvl_left == 0) begin
      if ($urandom_range(0, 3) != 0) lvl_want = ~lvl_want;
      lvl_left = run_length(cfg.lvl_conf, 1);
    end
    if (dc_left == 0) begin
      if ($urandom_range(0, 3) != 0) dc_want = ~dc_want;
      dc_left = run_length(cfg.dc_conf, 1);
    end
    pin_left--;
    lvl_left--;
    dc_left--;
    t.ready = $urandom_range(0, 19) != 0;
    t.pin = pin_want ^ ($urandom_range(0, 15) == 0);
    t.jadc = adc_near(!lvl_want, cfg.lvl_thr);
    t.dc = adc_near(dc_want, cfg.dc_thr);
    return t;
  endfunction

  task automatic send_tick(input tick_t t, input logic typed, input sense_t want);
    int     gap;
    sense_t predicted;
    gap = next_gap(SRC);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    driver_ready <= t.ready;
    jack_pin <= t.pin;
    jack_adc <= t.jadc;
    dc_adc <= t.dc;
    do @(posedge clk); while (!in_ready);
    predicted = qualify_tick(t);
    sense_q.push_back(typed ? want : predicted);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (sense_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POLL_PERIOD:    cfg.poll = data[CNT_W-1:0];
      REG_INSERT_CONFIRM: cfg.ins_conf = data[CNT_W-1:0];
      REG_LEVEL_THRESH:   cfg.lvl_thr = data[ADC_W-1:0];
      REG_LEVEL_CONFIRM:  cfg.lvl_conf = data[CNT_W-1:0];
      REG_DC_THRESH:      cfg.dc_thr = data[ADC_W-1:0];
      REG_DC_CONFIRM:     cfg.dc_conf = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] poll, input logic [CFG_DATA_W-1:0] ins,
                               input logic [CFG_DATA_W-1:0] lthr, input logic [CFG_DATA_W-1:0] lconf,
                               input logic [CFG_DATA_W-1:0] dthr, input logic [CFG_DATA_W-1:0] dconf,
                               input logic spare);
    cfg_write(REG_POLL_PERIOD, poll);
    cfg_write(REG_INSERT_CONFIRM, ins);
    cfg_write(REG_LEVEL_THRESH, lthr);
    cfg_write(REG_LEVEL_CONFIRM, lconf);
    cfg_write(REG_DC_THRESH, dthr);
    cfg_write(REG_DC_CONFIRM, dconf);
    if (spare) begin
      cfg_write(REG_SPARE_A, CFG_DATA_W'($urandom));
      cfg_write(REG_SPARE_B, CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : sink
    int gap;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      gap = next_gap(SNK);
      if (taken == 150 || taken == 1000) gap = LONG_HOLD;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  always @(posedge clk) begin : scoreboard
    sense_t got;
    sense_t want;
    if (!rst && out_valid && out_ready) begin
      got = {jack_inserted, jack_level_low, dc_present, insert_changed, level_changed,
             dc_changed};
      if (sense_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MAX_REPORTS) $display("%0t: result beat with none pending: %b", $realtime, got);
      end else begin
        want = sense_q.pop_front();
        if (got !== want) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS)
            $display("%0t: ins/lvl/dc exp %b%b%b got %b%b%b, chg exp %b%b%b got %b%b%b",
                     $realtime, want.inserted, want.level_low, want.dc_on, got.inserted,
                     got.level_low, got.dc_on, want.ins_chg, want.lvl_chg, want.dc_chg,
                     got.ins_chg, got.lvl_chg, got.dc_chg);
        end
      end
    end
  end

  initial begin : stimulus
    int n;
    cfg.poll = POLL_PERIOD_RST;
    cfg.ins_conf = CONFIRM_RST;
    cfg.lvl_thr = THRESH_RST;
    cfg.lvl_conf = CONFIRM_RST;
    cfg.dc_thr = THRESH_RST;
    cfg.dc_conf = CONFIRM_RST;
    st = '0;
    st.dc_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) send_tick(SCRIPT[i].t, SCRIPT[i].typed, SCRIPT[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_block();
      case (ph)
        0: load_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
        1: load_settings(12'd255, 12'd255, 12'd4095, 12'd255, 12'd4095, 12'd255, 1'b0);
        2: load_settings(12'd1, 12'd1, 12'd4095, 12'd1, 12'd0, 12'd1, 1'b0);
        default: begin
          load_settings({4'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                     : 8'($urandom_range(0, 5))},
                        {4'($urandom), 8'($urandom_range(0, 8))}, 12'($urandom),
                        {4'($urandom), 8'($urandom_range(0, 8))}, 12'($urandom),
                        {4'($urandom), 8'($urandom_range(0, 8))}, ph == 5);
        end
      endcase
      n = (ph == 1) ? 400 : 180;
      repeat (n) send_tick(random_tick(), 1'b0, UNTYPED);
    end
    drain_block();

    if (bad_beats == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/jpsq_pkg.sv
src/jpsq_debounce.sv
src/jack_and_power_sense_qualifier.sv
tb/tb.sv
